// File: hdl/indexed_array_list_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IALE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iale check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IALE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iale check failed");

`endif

// File: hdl/iale_pkg.sv
package iale_pkg;

  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 7;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] F_APPEND     = 3'd0;
  localparam logic [FUNC_W-1:0] F_INSERT     = 3'd1;
  localparam logic [FUNC_W-1:0] F_READ       = 3'd2;
  localparam logic [FUNC_W-1:0] F_WRITE      = 3'd3;
  localparam logic [FUNC_W-1:0] F_REMOVE_AT  = 3'd4;
  localparam logic [FUNC_W-1:0] F_REMOVE_VAL = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [2:0] P_HOLD  = 3'd0;
  localparam logic [2:0] P_IDX   = 3'd1;
  localparam logic [2:0] P_COUNT = 3'd2;
  localparam logic [2:0] P_ZERO  = 3'd3;
  localparam logic [2:0] P_INC   = 3'd4;
  localparam logic [2:0] P_DEC   = 3'd5;

  localparam logic [1:0] RA_PTR     = 2'd0;
  localparam logic [1:0] RA_PTR_DEC = 2'd1;
  localparam logic [1:0] RA_PTR_INC = 2'd2;

  localparam logic [1:0] WA_PTR   = 2'd0;
  localparam logic [1:0] WA_IDX   = 2'd1;
  localparam logic [1:0] WA_COUNT = 2'd2;

  localparam logic WD_VALUE = 1'b0;
  localparam logic WD_READ  = 1'b1;

  typedef struct packed {
    logic                start;
    logic [2:0]          ptr_op;
    logic                rd_en;
    logic [1:0]          rd_sel;
    logic                wr_en;
    logic [1:0]          wr_sel;
    logic                wr_src;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                capture;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                finish;
  } iale_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              room_ok;
    logic              idx_ok;
    logic              cnt_zero;
    logic              ptr_at_idx;
    logic              ptr_last;
    logic              match;
    logic              out_free;
  } iale_stat_t;

endpackage

// File: hdl/iale_datapath.sv
module iale_datapath #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [iale_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic [iale_pkg::FUNC_W-1:0]   func,
  input  logic [iale_pkg::INDEX_W-1:0]  index,
  input  logic [iale_pkg::VALUE_W-1:0]  value,
  input  iale_pkg::iale_cmd_t           cmd,
  output iale_pkg::iale_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iale_pkg::VALUE_W-1:0]  data,
  output logic [iale_pkg::STATUS_W-1:0] status,
  output logic [iale_pkg::LENGTH_W-1:0] length
);
  import iale_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + INDEX_W + 1;
  localparam int VW = DATA_WIDTH + VALUE_W;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CW-1:0]         count;
  logic [CAP_W-1:0]      capacity;
  logic [CW-1:0]         ptr;
  logic [FUNC_W-1:0]     req_func;
  logic [INDEX_W-1:0]    req_idx;
  logic [DATA_WIDTH-1:0] req_val;
  logic [DATA_WIDTH-1:0] data_r;
  logic [STATUS_W-1:0]   status_r;

  logic [XW-1:0]         count_x;
  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         ptr_x;
  logic [XW-1:0]         cap_x;
  logic [CW-1:0]         ptr_dec;
  logic [CW-1:0]         ptr_inc;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [VW-1:0]         val_wide;
  logic [VW-1:0]         data_wide;

  assign count_x   = XW'(count);
  assign idx_x     = XW'(req_idx);
  assign ptr_x     = XW'(ptr);
  assign cap_x     = XW'(capacity);
  assign ptr_dec   = ptr - CW'(1);
  assign ptr_inc   = ptr + CW'(1);
  assign val_wide  = VW'(value);
  assign data_wide = VW'(data_r);
  assign wr_data   = (cmd.wr_src == WD_READ) ? rd_data : req_val;

  always_comb begin
    case (cmd.rd_sel)
      RA_PTR_DEC: rd_addr = ptr_dec[AW-1:0];
      RA_PTR_INC: rd_addr = ptr_inc[AW-1:0];
      default:    rd_addr = ptr[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WA_IDX:   wr_addr = idx_x[AW-1:0];
      WA_COUNT: wr_addr = count[AW-1:0];
      default:  wr_addr = ptr[AW-1:0];
    endcase
  end

  always_comb begin
    stat.func       = req_func;
    stat.room_ok    = (count_x < CAP_X) && (count_x < cap_x);
    stat.idx_ok     = idx_x < count_x;
    stat.cnt_zero   = (count == '0);
    stat.ptr_at_idx = (ptr_x == idx_x);
    stat.ptr_last   = (ptr_x + XW'(1)) >= count_x;
    stat.match      = (rd_data == req_val);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= CAP_RESET;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      case (cmd.ptr_op)
        P_IDX:   ptr <= idx_x[CW-1:0];
        P_COUNT: ptr <= count;
        P_ZERO:  ptr <= '0;
        P_INC:   ptr <= ptr_inc;
        P_DEC:   ptr <= ptr_dec;
        default: ptr <= ptr;
      endcase
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_func <= func;
      req_idx  <= index;
      req_val  <= val_wide[DATA_WIDTH-1:0];
      data_r   <= '0;
    end else if (cmd.capture) begin
      data_r <= rd_data;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.finish) begin
      data   <= data_wide[VALUE_W-1:0];
      status <= status_r;
      length <= count_x[LENGTH_W-1:0];
    end
  end

endmodule

// File: hdl/iale_controller.sv
module iale_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iale_pkg::iale_stat_t stat,
  output iale_pkg::iale_cmd_t  cmd
);
  import iale_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_RD       = 4'd4;
  localparam logic [3:0] S_CAP      = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CMP = 4'd7;
  localparam logic [3:0] S_DEL_RD   = 4'd8;
  localparam logic [3:0] S_DEL_WR   = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_IGNORED;
        state_next     = S_FIN;
        case (stat.func)
          F_APPEND: begin
            if (stat.room_ok) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WA_COUNT;
              cmd.wr_src  = WD_VALUE;
              cmd.cnt_inc = 1'b1;
              cmd.status  = ST_DONE;
            end
          end
          F_INSERT: begin
            if (stat.room_ok && stat.idx_ok) begin
              cmd.ptr_op = P_COUNT;
              cmd.status = ST_DONE;
              state_next = S_INS_RD;
            end
          end
          F_READ, F_REMOVE_AT: begin
            if (stat.idx_ok) begin
              cmd.ptr_op = P_IDX;
              cmd.status = ST_DONE;
              state_next = S_RD;
            end else begin
              cmd.status = ST_RANGE;
            end
          end
          F_WRITE: begin
            if (stat.idx_ok) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WA_IDX;
              cmd.wr_src = WD_VALUE;
              cmd.status = ST_DONE;
            end
          end
          F_REMOVE_VAL: begin
            cmd.status = ST_NOTFOUND;
            if (!stat.cnt_zero) begin
              cmd.ptr_op = P_ZERO;
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            cmd.status = ST_IGNORED;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.ptr_at_idx) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WA_PTR;
          cmd.wr_src  = WD_VALUE;
          cmd.cnt_inc = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_DEC;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_PTR;
        cmd.wr_src = WD_READ;
        cmd.ptr_op = P_DEC;
        state_next = S_INS_RD;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_PTR;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.capture = 1'b1;
        state_next  = (stat.func == F_READ) ? S_FIN : S_DEL_RD;
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_PTR;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          cmd.capture    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_DONE;
          state_next     = S_DEL_RD;
        end else if (stat.ptr_last) begin
          state_next = S_FIN;
        end else begin
          cmd.ptr_op = P_INC;
          state_next = S_SCAN_RD;
        end
      end
      S_DEL_RD: begin
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_INC;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_PTR;
        cmd.wr_src = WD_READ;
        cmd.ptr_op = P_INC;
        state_next = S_DEL_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/indexed_array_list_engine.sv
// Channel   Handshake             Payload
// -------   --------------------  ----------------------
// request   in_valid / in_ready   func, index, value
// result    out_valid / out_ready data, status, length
// config    cfg_we                cfg_wdata (capacity)
//
// Insert shifts the entries from index onward up by one before writing the value; remove at
// index shifts the entries after index down by one. Remove by value scans from the first
// entry for a match before the same shift; each entry move is a registered read followed by a
// write.
// Reset clears the length and sets capacity to 64; entry contents are not cleared.
// A finished result waits in the output register, and new requests are taken meanwhile.
module indexed_array_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [iale_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iale_pkg::FUNC_W-1:0]   func,
  input  logic [iale_pkg::INDEX_W-1:0]  index,
  input  logic [iale_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iale_pkg::VALUE_W-1:0]  data,
  output logic [iale_pkg::STATUS_W-1:0] status,
  output logic [iale_pkg::LENGTH_W-1:0] length
);
  import iale_pkg::*;

  iale_cmd_t  cmd;
  iale_stat_t stat;

  iale_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iale_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .func      (func),
    .index     (index),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (data),
    .status    (status),
    .length    (length)
  );

endmodule

// File: hdl/iale_checker.sv
`include "indexed_array_list_engine_assert.svh"

module iale_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [iale_pkg::VALUE_W-1:0]  data,
  input logic [iale_pkg::STATUS_W-1:0] status,
  input logic [iale_pkg::LENGTH_W-1:0] length
);
  import iale_pkg::*;

  // A taken request keeps the engine busy for at least the next cycle.
  `IALE_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)

  `IALE_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid)

  `IALE_ASSERT_NEXT(a_payload_holds, out_valid && !out_ready, $stable({data, status, length}))

  // Failed requests never report entry data.
  `IALE_ASSERT_NOW(a_fail_no_data, out_valid && (status != ST_DONE), data == '0)

endmodule

bind indexed_array_list_engine iale_checker u_checker (.*);
